// File: sv/gif_frame_compositor_unit_assert.svh
// Assertion macros for the GIF frame compositor.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef GIF_FRAME_COMPOSITOR_UNIT_ASSERT_SVH
`define GIF_FRAME_COMPOSITOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GFC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define GFC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GFC_ASSERT_IMP(lbl, ante, cons, msg)
`define GFC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: sv/gfc_pkg.sv
// Shared types, constants and tables of the GIF frame compositor.
// No dependencies; compiled first.
package gfc_pkg;

    localparam int PAL_ENTRIES  = 256;
    localparam int PAL_AW       = $clog2(PAL_ENTRIES);
    localparam int ADDRESS_BITS = 24;
    localparam int ADDR_OUT_W   = 24;
    localparam int ADDR_KEEP    = (ADDRESS_BITS < ADDR_OUT_W) ? ADDRESS_BITS : ADDR_OUT_W;
    localparam int COLOR_W      = 32;
    localparam int ROW_W        = 14;
    localparam int COL_W        = 14;
    localparam int CFG_DATA_W   = 17;

    localparam logic [1:0] DISP_BKGD = 2'd2;
    localparam logic [1:0] DISP_PREV = 2'd3;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_PIXEL = 2'd1,
        FN_END   = 2'd2,
        FN_TICK  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CFG_CANVAS_WIDTH   = 3'd0,
        CFG_CANVAS_HEIGHT  = 3'd1,
        CFG_FRAME_LEFT     = 3'd2,
        CFG_FRAME_TOP      = 3'd3,
        CFG_FRAME_COLS     = 3'd4,
        CFG_FRAME_ROWS     = 3'd5,
        CFG_FRAME_MODE     = 3'd6,
        CFG_INDEX_SETTINGS = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [12:0] canvas_width;
        logic [12:0] canvas_height;
        logic [11:0] frame_left;
        logic [11:0] frame_top;
        logic [12:0] frame_cols;
        logic [12:0] frame_rows;
        logic [4:0]  frame_mode;
        logic [16:0] index_settings;
    } t_cfg;

    // request handed from the walker to the emit stage
    typedef struct packed {
        logic             emit;
        logic             fill_ld;
        logic             use_fill;
        logic             mask_alpha;
        logic             pal_zero;
        logic             buf_sel;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_s1;

    function automatic logic [2:0] pass_start(input logic [1:0] p);
        logic [2:0] v;
        case (p)
            2'd0:    v = 3'd0;
            2'd1:    v = 3'd4;
            2'd2:    v = 3'd2;
            default: v = 3'd1;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] pass_step(input logic [1:0] p);
        logic [3:0] v;
        case (p)
            2'd0:    v = 4'd8;
            2'd1:    v = 4'd8;
            2'd2:    v = 4'd4;
            default: v = 4'd2;
        endcase
        return v;
    endfunction

endpackage

// File: sv/gfc_in_if.sv
// Input word channel of the GIF frame compositor.
// Standalone; valid/ready handshake with the item fields.
interface gfc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  palette_slot;
    logic [31:0] entry_color;
    logic [7:0]  pixel_value;

    modport source (output valid, func, palette_slot, entry_color, pixel_value, input ready);
    modport sink   (input valid, func, palette_slot, entry_color, pixel_value, output ready);
endinterface

// File: sv/gfc_out_if.sv
// Result word channel of the GIF frame compositor (canvas writes).
// Standalone; valid/ready handshake with the write fields.
interface gfc_out_if;
    logic        valid;
    logic        ready;
    logic        buffer_select;
    logic [23:0] canvas_address;
    logic [31:0] pixel_color;
    logic        fill_last;

    modport source (output valid, buffer_select, canvas_address, pixel_color, fill_last,
                     input ready);
    modport sink   (input valid, buffer_select, canvas_address, pixel_color, fill_last,
                     output ready);
endinterface

// File: sv/gfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/gfc_walk.sv
// Cursor walker: interlace/straight pixel placement, disposal and fill sequencing.
// Depends on gfc_pkg; issues palette reads and emit requests.
module gfc_walk (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gfc_pkg::t_cfg i_cfg,
    input  logic          i_acc,
    input  logic [1:0]    i_func,
    input  logic [7:0]    i_pixel_value,
    output gfc_pkg::t_s1  o_req,
    output logic          o_rd_en,
    output logic [7:0]    o_rd_idx,
    output logic          o_fill_active
);
    import gfc_pkg::*;

    logic [1:0]  r_pass, n_pass;
    logic [12:0] r_row, n_row;
    logic [12:0] r_col, n_col;
    logic [11:0] r_fill_row, n_fill_row;
    logic [12:0] r_fill_col, n_fill_col;
    logic        r_fill_active, n_fill_active;
    logic        r_fill_whole, n_fill_whole;
    logic        r_abuf, n_abuf;

    logic        interlace, first, transp;
    logic [1:0]  disp, eff_disp;
    logic [8:0]  tidx;
    logic [7:0]  bidx;

    // pixel walk
    logic        p_ok, p_in;
    logic [3:0]  st0, st1;
    logic [1:0]  p1;
    logic [12:0] r1, r2, c1, c2;

    // fill walk
    logic [12:0] fw, fh;
    logic [11:0] fr0, fc0;
    logic        t_zero, t_last;
    logic [13:0] fc_inc;

    // disposal
    logic [7:0]  end_idx;

    assign interlace = i_cfg.frame_mode[0];
    assign first     = i_cfg.frame_mode[1];
    assign transp    = i_cfg.frame_mode[2];
    assign disp      = i_cfg.frame_mode[4:3];
    assign tidx      = i_cfg.index_settings[8:0];
    assign bidx      = i_cfg.index_settings[16:9];
    assign eff_disp  = (disp == DISP_PREV && first) ? DISP_BKGD : disp;
    assign end_idx   = (transp && !tidx[8]) ? tidx[7:0] : bidx;

    always_comb begin
        p_ok = (i_cfg.frame_cols != '0) && (i_cfg.frame_rows != '0);
        st0  = interlace ? pass_step(r_pass) : 4'd1;
        c1   = r_col;
        r1   = r_row;
        if (r_col >= i_cfg.frame_cols) begin
            c1 = '0;
            r1 = r_row + 13'(st0);
        end
        // skip passes that have no rows in this rectangle
        p1 = r_pass;
        for (int k = 0; k < 3; k++) begin
            if (interlace && r1 >= i_cfg.frame_rows && p1 != 2'd3) begin
                p1 = p1 + 2'd1;
                r1 = 13'(pass_start(p1));
            end
        end
        p_in = r1 < i_cfg.frame_rows;
        st1  = interlace ? pass_step(p1) : 4'd1;
        c2   = c1 + 13'd1;
        r2   = r1;
        if (c2 >= i_cfg.frame_cols) begin
            c2 = '0;
            r2 = r1 + 13'(st1);
        end
    end

    always_comb begin
        fw     = r_fill_whole ? i_cfg.canvas_width  : i_cfg.frame_cols;
        fh     = r_fill_whole ? i_cfg.canvas_height : i_cfg.frame_rows;
        fr0    = r_fill_whole ? 12'd0 : i_cfg.frame_top;
        fc0    = r_fill_whole ? 12'd0 : i_cfg.frame_left;
        t_zero = (fw == '0) || (fh == '0);
        t_last = ({1'b0, r_fill_row} >= fh - 13'd1) && (r_fill_col >= fw - 13'd1);
        fc_inc = 14'(r_fill_col) + 14'd1;
    end

    always_comb begin
        n_pass        = r_pass;
        n_row         = r_row;
        n_col         = r_col;
        n_fill_row    = r_fill_row;
        n_fill_col    = r_fill_col;
        n_fill_active = r_fill_active;
        n_fill_whole  = r_fill_whole;
        n_abuf        = r_abuf;
        o_req         = '0;
        o_req.buf_sel = r_abuf;
        o_rd_en       = 1'b0;
        o_rd_idx      = i_pixel_value;
        unique case (t_func'(i_func))
            FN_LOAD: begin
            end
            FN_PIXEL: begin
                if (p_ok) begin
                    n_pass = p1;
                    if (p_in) begin
                        n_row = r2;
                        n_col = c2;
                        if ({1'b0, i_pixel_value} != tidx) begin
                            o_req.emit     = 1'b1;
                            o_req.pal_zero = {1'b0, i_pixel_value} >= 9'(PAL_ENTRIES);
                            o_req.row      = 14'(i_cfg.frame_top) + 14'(r1);
                            o_req.col      = 14'(i_cfg.frame_left) + 14'(c1);
                            o_rd_en        = 1'b1;
                        end
                    end else begin
                        n_row = r1;
                        n_col = c1;
                    end
                end
            end
            FN_END: begin
                n_pass = '0;
                n_row  = '0;
                n_col  = '0;
                if (eff_disp == DISP_PREV) begin
                    n_abuf = ~r_abuf;
                end else if (eff_disp == DISP_BKGD) begin
                    n_fill_whole  = first;
                    n_fill_row    = '0;
                    n_fill_col    = '0;
                    n_fill_active = first
                        ? (i_cfg.canvas_width != '0 && i_cfg.canvas_height != '0)
                        : (i_cfg.frame_cols != '0 && i_cfg.frame_rows != '0);
                    o_req.fill_ld    = 1'b1;
                    o_req.mask_alpha = transp;
                    o_req.pal_zero   = {1'b0, end_idx} >= 9'(PAL_ENTRIES);
                    o_rd_idx         = end_idx;
                    o_rd_en          = 1'b1;
                end
            end
            FN_TICK: begin
                if (r_fill_active) begin
                    if (t_zero || t_last) begin
                        n_fill_active = 1'b0;
                        n_fill_row    = '0;
                        n_fill_col    = '0;
                    end else if (fc_inc >= 14'(fw)) begin
                        n_fill_col = '0;
                        n_fill_row = r_fill_row + 12'd1;
                    end else begin
                        n_fill_col = 13'(fc_inc);
                    end
                    if (!t_zero) begin
                        o_req.emit     = 1'b1;
                        o_req.use_fill = 1'b1;
                        o_req.last     = t_last;
                        o_req.row      = 14'(fr0) + 14'(r_fill_row);
                        o_req.col      = 14'(fc0) + 14'(r_fill_col);
                    end
                end
            end
            default: begin
            end
        endcase
        if (!i_acc) begin
            o_req.emit    = 1'b0;
            o_req.fill_ld = 1'b0;
            o_rd_en       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass        <= '0;
            r_row         <= '0;
            r_col         <= '0;
            r_fill_row    <= '0;
            r_fill_col    <= '0;
            r_fill_active <= 1'b0;
            r_fill_whole  <= 1'b0;
            r_abuf        <= 1'b0;
        end else if (i_acc) begin
            r_pass        <= n_pass;
            r_row         <= n_row;
            r_col         <= n_col;
            r_fill_row    <= n_fill_row;
            r_fill_col    <= n_fill_col;
            r_fill_active <= n_fill_active;
            r_fill_whole  <= n_fill_whole;
            r_abuf        <= n_abuf;
        end
    end

    assign o_fill_active = r_fill_active;
endmodule

// File: sv/gfc_emit.sv
// Emit stage: palette data select, canvas address multiply, output register.
// Depends on gfc_pkg and gfc_out_if.
module gfc_emit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gfc_pkg::t_s1                 i_req,
    input  logic [12:0]                  i_canvas_width,
    input  logic [gfc_pkg::COLOR_W-1:0]  i_rdata,
    output logic                         o_take,
    gfc_out_if.source                    o_res
);
    import gfc_pkg::*;

    logic               r_s1_v;
    t_s1                r_s1;
    logic [COLOR_W-1:0] r_fill_color;
    logic               r_out_v;
    logic               r_out_buf;
    logic [ADDR_OUT_W-1:0] r_out_addr;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_last;

    logic               s1_move;
    logic [COLOR_W-1:0] pal, pal_fill, color;
    logic [26:0]        prod;
    logic [27:0]        sum;

    // S1 drains unless it holds a write and the output register is blocked
    assign s1_move = r_s1_v && (!r_s1.emit || !r_out_v || o_res.ready);
    assign o_take  = !r_s1_v || s1_move;

    assign pal      = r_s1.pal_zero ? '0 : i_rdata;
    assign pal_fill = r_s1.mask_alpha ? {8'h00, pal[23:0]} : pal;
    assign color    = r_s1.use_fill ? r_fill_color : pal;
    assign prod     = 27'(i_canvas_width) * 27'(r_s1.row);
    assign sum      = 28'(prod) + 28'(r_s1.col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_take) begin
                r_s1_v <= i_req.emit || i_req.fill_ld;
            end
            if (s1_move && r_s1.emit) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_s1 <= i_req;
        end
        if (s1_move && r_s1.fill_ld) begin
            r_fill_color <= pal_fill;
        end
        if (s1_move && r_s1.emit) begin
            r_out_buf   <= r_s1.buf_sel;
            r_out_addr  <= ADDR_OUT_W'(sum[ADDR_KEEP-1:0]);
            r_out_color <= color;
            r_out_last  <= r_s1.last;
        end
    end

    assign o_res.valid          = r_out_v;
    assign o_res.buffer_select  = r_out_buf;
    assign o_res.canvas_address = r_out_addr;
    assign o_res.pixel_color    = r_out_color;
    assign o_res.fill_last      = r_out_last;
endmodule

// File: sv/gif_frame_compositor_unit.sv
// Writes pass S1, then the output register, to o_result; a blocked write stalls S1.
// Throughput: otherwise one word per cycle; the palette RAM read port and the address
//   multiplier each serve one word a cycle, and the output register holds one write.
// Reset (i_rst_n low at a clock edge): cursors, fill state, buffer select and the
//   configuration registers return to their defaults; palette contents are undefined
//   until loaded, so no clearing pass runs and words are taken right after reset.
`include "gif_frame_compositor_unit_assert.svh"
module gif_frame_compositor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    gfc_in_if.sink      i_item,
    gfc_out_if.source   o_result
);
    import gfc_pkg::*;

    // Datapath overview
    //   accept edge : walker updates cursors/fill state, palette RAM read issued,
    //                 loads written straight into the RAM
    //   S1          : palette data back, width*row + col, fill color latch
    //   output reg  : canvas write held until the sink takes it
    // A fill tick that follows a background disposal reads the fill color the
    // cycle after the disposal word has left S1, so program order is kept.

    t_cfg  r_cfg, n_cfg;
    t_s1   req;
    logic  acc;
    logic  take;
    logic  ram_we, ram_re;
    logic  [7:0] rd_idx;
    logic  [COLOR_W-1:0] rdata;
    logic  fill_active;

    // Configuration registers; the user writes them only while the block is idle (not enforced)
    always_comb begin
        n_cfg = r_cfg;
        unique case (t_cfg_idx'(i_cfg_idx))
            CFG_CANVAS_WIDTH:   n_cfg.canvas_width   = 13'(i_cfg_data);
            CFG_CANVAS_HEIGHT:  n_cfg.canvas_height  = 13'(i_cfg_data);
            CFG_FRAME_LEFT:     n_cfg.frame_left     = 12'(i_cfg_data);
            CFG_FRAME_TOP:      n_cfg.frame_top      = 12'(i_cfg_data);
            CFG_FRAME_COLS:     n_cfg.frame_cols     = 13'(i_cfg_data);
            CFG_FRAME_ROWS:     n_cfg.frame_rows     = 13'(i_cfg_data);
            CFG_FRAME_MODE:     n_cfg.frame_mode     = 5'(i_cfg_data);
            CFG_INDEX_SETTINGS: n_cfg.index_settings = i_cfg_data;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.canvas_width   <= 13'd256;
            r_cfg.canvas_height  <= 13'd256;
            r_cfg.frame_left     <= '0;
            r_cfg.frame_top      <= '0;
            r_cfg.frame_cols     <= 13'd1;
            r_cfg.frame_rows     <= 13'd1;
            r_cfg.frame_mode     <= '0;
            r_cfg.index_settings <= 17'd65792;  // no transparent index, background 128
        end else if (i_cfg_we) begin
            r_cfg <= n_cfg;
        end
    end

    // Handshake: a word is taken whenever S1 is empty or can drain
    assign i_item.ready = take;
    assign acc          = i_item.valid && take;

    // Palette loads beyond the store are dropped
    assign ram_we = acc && (t_func'(i_item.func) == FN_LOAD)
                    && ({1'b0, i_item.palette_slot} < 9'(PAL_ENTRIES));

    gfc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PAL_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_item.palette_slot[PAL_AW-1:0]),
        .i_wdata (i_item.entry_color),
        .i_re    (ram_re),
        .i_raddr (rd_idx[PAL_AW-1:0]),
        .o_rdata (rdata)
    );

    gfc_walk u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_acc         (acc),
        .i_func        (i_item.func),
        .i_pixel_value (i_item.pixel_value),
        .o_req         (req),
        .o_rd_en       (ram_re),
        .o_rd_idx      (rd_idx),
        .o_fill_active (fill_active)
    );

    gfc_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .i_canvas_width (r_cfg.canvas_width),
        .i_rdata        (rdata),
        .o_take         (take),
        .o_res          (o_result)
    );

    // A load and a palette read never share a cycle (one word per cycle)
    `GFC_ASSERT_IMP(a_ram_port_excl, ram_we, !ram_re, "palette write and read in one cycle")
    // The last fill write closes the fill
    `GFC_ASSERT_NXT(a_fill_ends, acc && req.emit && req.last, !fill_active, "fill still armed after last write")
    // Input stalls only behind a blocked output write
    `GFC_ASSERT_IMP(a_stall_cause, !i_item.ready, o_result.valid && !o_result.ready, "input stalled without output backpressure")
endmodule
